// ----- design/lcgr_pkg.sv -----
// ----------------------------------------------------------------------------
// lcgr_pkg
// Shared types and constants for the ranged LCG random number block:
// channel payloads, action codes, generator constants and the
// controller-to-datapath command group.
// ----------------------------------------------------------------------------
package lcgr_pkg;

    // Generator constants
    localparam logic [31:0] LCG_MULT  = 32'd1664525;
    localparam logic [31:0] LCG_INC   = 32'd1013904223;
    localparam logic [31:0] LCG_RESET = 32'd4367;

    // Divider length: one quotient bit per step
    localparam int unsigned DIV_STEPS = 32;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    // Action codes
    localparam logic ACT_DRAW = 1'b0;
    localparam logic ACT_SEED = 1'b1;

    typedef struct packed {
        logic               action;
        logic signed [31:0] lower_bound;
        logic signed [31:0] upper_bound;
        logic        [31:0] seed_value;
    } in_item_t;

    typedef struct packed {
        logic [31:0] ranged_value;
        logic [31:0] raw_state;
    } out_item_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_seed;   // copy seed into generator state
        logic load_draw;   // capture lower bound and span
        logic advance;     // step generator, start remainder
        logic div_step;    // one restoring remainder step
        logic load_out;    // write result register
    } lcgr_cmd_t;

endpackage

// ----- design/lcgr_ctrl.sv -----
// ----------------------------------------------------------------------------
// lcgr_ctrl
// Controller: sequences seed loads and draws, counts divider steps and
// owns the result valid flag.
// ----------------------------------------------------------------------------
module lcgr_ctrl
    import lcgr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_action,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    output lcgr_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_ADVANCE = 4'b0010,
        ST_DIVIDE  = 4'b0100,
        ST_FINISH  = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;
    logic             take_in;
    logic             out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign take_in   = in_valid && (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    // Decode state into commands and next state
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take_in)
                begin
                    if (in_action == ACT_SEED)
                    begin
                        cmd.load_seed = 1'b1;
                    end
                    else
                    begin
                        cmd.load_draw = 1'b1;
                        state_next    = ST_ADVANCE;
                    end
                end
            end
            ST_ADVANCE:
            begin
                cmd.advance = 1'b1;
                count_next  = '0;
                state_next  = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                count_next   = count_reg + 1'b1;
                if (count_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Set valid on a new result, drop it once the beat is taken
    always_comb
    begin
        priority if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- design/lcgr_dp.sv -----
// ----------------------------------------------------------------------------
// lcgr_dp
// Datapath: generator state, LCG step, restoring remainder unit and the
// result register.
// ----------------------------------------------------------------------------
module lcgr_dp
    import lcgr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  lcgr_cmd_t cmd,
    input  in_item_t  in_data,
    output out_item_t out_data
);

    logic [31:0] gen_state_reg, gen_state_next;
    logic [31:0] lower_reg;
    logic [31:0] span_reg;
    logic [31:0] dvd_reg;
    logic [31:0] rem_reg;
    out_item_t   out_reg;
    logic [31:0] adv_value;
    logic [32:0] shifted;
    logic [33:0] diff;
    logic [31:0] rem_step;

    // Next generator value
    assign adv_value = gen_state_reg * LCG_MULT + LCG_INC;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign shifted  = {rem_reg, dvd_reg[31]};
    assign diff     = {1'b0, shifted} - {2'b00, span_reg};
    assign rem_step = diff[33] ? shifted[31:0] : diff[31:0];

    // Load seed or advance the generator
    always_comb
    begin
        priority if (cmd.load_seed)
        begin
            gen_state_next = in_data.seed_value;
        end
        else if (cmd.advance)
        begin
            gen_state_next = adv_value;
        end
        else
        begin
            gen_state_next = gen_state_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_state_reg <= LCG_RESET;
        end
        else
        begin
            gen_state_reg <= gen_state_next;
        end
    end

    // Capture the range of a draw
    always_ff @(posedge clk)
    begin
        if (cmd.load_draw)
        begin
            lower_reg <= $unsigned(in_data.lower_bound);
            span_reg  <= $unsigned(in_data.upper_bound) - $unsigned(in_data.lower_bound)
                         + 32'd1;
        end
    end

    // Remainder unit
    always_ff @(posedge clk)
    begin
        if (cmd.advance)
        begin
            dvd_reg <= adv_value;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            rem_reg <= rem_step;
        end
    end

    // Result register; a zero span means the full range
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg.raw_state <= gen_state_reg;
            if (span_reg == 32'd0)
            begin
                out_reg.ranged_value <= gen_state_reg + lower_reg;
            end
            else
            begin
                out_reg.ranged_value <= lower_reg + rem_reg;
            end
        end
    end

    assign out_data = out_reg;

endmodule

// ----- design/lcg_random_in_range.sv -----
// ----------------------------------------------------------------------------
// lcg_random_in_range
// Ranged linear congruential random number generator, top level.
// ----------------------------------------------------------------------------
// A seed beat (action = 1) loads the 32-bit generator state in the cycle it
// is accepted and gives no result; the block is ready again at once. A draw
// beat (action = 0) steps the state by state * 1664525 + 1013904223 and
// returns the new state with lower_bound + (state mod span), where
// span = upper_bound - lower_bound + 1 wraps at 32 bits and a zero span
// returns state + lower_bound. A draw runs the generator step, the
// bit-serial restoring remainder unit (one quotient bit per cycle) and a
// write of the result register, which waits while an earlier result is
// stalled. Input is stalled during a draw; a finished result may wait in
// its register while the next beat is accepted. The state resets to 4367.
module lcg_random_in_range
    import lcgr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    lcgr_cmd_t cmd;

    lcgr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_action (in_data.action),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    lcgr_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .out_data (out_data)
    );

endmodule

// ----- design/lcgr_checker.sv -----
// ----------------------------------------------------------------------------
// lcgr_checker
// Port-level checks for lcg_random_in_range, bound to the top level.
// ----------------------------------------------------------------------------
module lcgr_checker
    import lcgr_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input in_item_t  in_data,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    // Hold a stalled result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result beat changed");

    // A draw occupies the block
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (in_data.action == ACT_DRAW) |=> in_stall)
        else $error("input not stalled after draw");

    // A seed load leaves the block ready
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (in_data.action == ACT_SEED) |=> !in_stall)
        else $error("input stalled after seed load");

    // A new result only ends a draw in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall) && !in_stall)
        else $error("result appeared outside a draw");

endmodule

bind lcg_random_in_range lcgr_checker u_lcgr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
